[rtl/wfsa_pkg.sv]
`default_nettype none
package wfsa_pkg;

   localparam int MaxSegments = 16;
   localparam int AddrBits    = 16;
   localparam int IdxBits     = $clog2(MaxSegments);
   localparam int CntBits     = $clog2(MaxSegments + 1);

   typedef logic [AddrBits-1:0] addr_type;
   typedef logic [IdxBits-1:0]  idx_type;
   typedef logic [CntBits-1:0]  cnt_type;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_INIT  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_ZERO    = 2'd3
   } status_type;

   // one table entry: base in the low half, length in the high half
   typedef struct packed {
      addr_type len;
      addr_type base;
   } seg_type;

   // memory port driven by the sequencer
   typedef struct packed {
      logic    rd_en;
      idx_type rd_addr;
      logic    wr_en;
      idx_type wr_addr;
      seg_type wr_data;
   } mem_cmd_type;

endpackage
`default_nettype wire

[rtl/wfsa_seg_ram.sv]
`default_nettype none
module wfsa_seg_ram (
   input  wire                   clock,
   input  wfsa_pkg::mem_cmd_type cmd,
   output wfsa_pkg::seg_type     rd_data
);
   import wfsa_pkg::*;

   seg_type mem [MaxSegments];
   seg_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/wfsa_seq.sv]
`default_nettype none
module wfsa_seq (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire                   out_ready,
   input  wire [1:0]             action,
   input  wfsa_pkg::addr_type    req_len,
   input  wfsa_pkg::addr_type    req_base,
   input  wfsa_pkg::addr_type    total_size,
   input  wfsa_pkg::seg_type     rd_data,
   output wfsa_pkg::mem_cmd_type cmd,
   output logic                  done,
   output logic [1:0]            status,
   output wfsa_pkg::addr_type    granted,
   output wfsa_pkg::cnt_type     count
);
   import wfsa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,      // read entries one by one
      S_ALLOC_WR,  // write back the carved segment
      S_FREE_PREV, // read entry pos-1
      S_FREE_NEXT, // read entry pos
      S_FREE_DEC,
      S_SHIFT_L,   // move entries down one slot
      S_SHIFT_R,   // move entries up one slot
      S_PUT,
      S_DONE
   } state_type;

   localparam logic [AddrBits:0] LenMax = {1'b0, {AddrBits{1'b1}}};

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   cnt_type   idx_ff, idx_in;     // next entry to issue
   logic      rvld_ff, rvld_in;   // read issued last cycle
   cnt_type   ridx_ff, ridx_in;   // index of returning read
   logic      found_ff, found_in;
   idx_type   pick_ff, pick_in;
   seg_type   best_ff, best_in;
   seg_type   prev_ff, prev_in;
   seg_type   next_ff, next_in;
   cnt_type   pos_ff, pos_in;
   seg_type   put_ff, put_in;
   logic      is_free_ff, is_free_in;
   logic [1:0] status_ff, status_in;
   addr_type  granted_ff, granted_in;
   mem_cmd_type cmd_c;

   logic [AddrBits:0] sum_a, sum_b, sum_c;
   addr_type new_len;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      rvld_in    = 1'b0;
      ridx_in    = idx_ff;
      found_in   = found_ff;
      pick_in    = pick_ff;
      best_in    = best_ff;
      prev_in    = prev_ff;
      next_in    = next_ff;
      pos_in     = pos_ff;
      put_in     = put_ff;
      is_free_in = is_free_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      cmd_c      = '0;
      sum_a      = '0;
      sum_b      = '0;
      sum_c      = '0;
      new_len    = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in  = ST_OK;
               granted_in = '0;
               found_in   = 1'b0;
               idx_in     = '0;
               pos_in     = '0;
               is_free_in = (action == ACT_FREE);
               put_in     = '{len: req_len, base: req_base};
               state_in   = S_DONE;
               case (action)
                  ACT_ALLOC, ACT_FREE: begin
                     if (req_len == '0) status_in = ST_ZERO;
                     else state_in = S_SCAN;
                  end
                  ACT_INIT: begin
                     count_in = '0;
                     if (total_size != '0) begin
                        cmd_c.wr_en   = 1'b1;
                        cmd_c.wr_addr = '0;
                        cmd_c.wr_data = '{len: total_size, base: '0};
                        count_in      = cnt_type'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_SCAN: begin
            // issue next read
            if (idx_ff < count_ff) begin
               cmd_c.rd_en   = 1'b1;
               cmd_c.rd_addr = idx_ff[IdxBits-1:0];
               rvld_in       = 1'b1;
               ridx_in       = idx_ff;
               idx_in        = idx_ff + 1'b1;
            end
            if (rvld_ff) begin
               if (!is_free_ff) begin
                  if (rd_data.len >= put_ff.len &&
                      (!found_ff || rd_data.len > best_ff.len)) begin
                     found_in = 1'b1;
                     best_in  = rd_data;
                     pick_in  = ridx_ff[IdxBits-1:0];
                  end
               end else if (rd_data.base <= put_ff.base) begin
                  pos_in  = ridx_ff + 1'b1;
                  prev_in = rd_data;
               end else begin
                  // first entry above: stop the scan
                  next_in = rd_data;
                  rvld_in = 1'b0;
                  idx_in  = count_ff;
               end
            end
            if (!(idx_ff < count_ff) && !rvld_ff ||
                (rvld_ff && is_free_ff && rd_data.base > put_ff.base)) begin
               rvld_in = 1'b0;
               state_in = is_free_ff ? S_FREE_DEC : S_ALLOC_WR;
            end
         end

         S_ALLOC_WR: begin
            if (!found_ff) begin
               status_in = ST_NO_FIT;
               state_in  = S_DONE;
            end else begin
               granted_in = best_ff.base;
               new_len    = best_ff.len - put_ff.len;
               if (new_len == '0) begin
                  idx_in   = {1'b0, pick_ff};
                  state_in = S_SHIFT_L;
               end else begin
                  cmd_c.wr_en   = 1'b1;
                  cmd_c.wr_addr = pick_ff;
                  cmd_c.wr_data = '{len: new_len, base: best_ff.base + put_ff.len};
                  state_in      = S_DONE;
               end
            end
         end

         S_FREE_DEC: begin
            // prev_ff is entry pos-1, next_ff is entry pos (when present)
            sum_a = {1'b0, prev_ff.len} + {1'b0, put_ff.len};
            sum_b = sum_a + {1'b0, next_ff.len};
            sum_c = {1'b0, put_ff.len} + {1'b0, next_ff.len};
            state_in = S_DONE;
            if (pos_ff != '0 && prev_ff.base + prev_ff.len == put_ff.base &&
                sum_a <= LenMax) begin
               cmd_c.wr_en   = 1'b1;
               cmd_c.wr_addr = pos_ff[IdxBits-1:0] - 1'b1;
               if (pos_ff < count_ff && put_ff.base + put_ff.len == next_ff.base &&
                   sum_b <= LenMax) begin
                  cmd_c.wr_data = '{len: sum_b[AddrBits-1:0], base: prev_ff.base};
                  idx_in        = pos_ff;
                  state_in      = S_SHIFT_L;
               end else begin
                  cmd_c.wr_data = '{len: sum_a[AddrBits-1:0], base: prev_ff.base};
               end
            end else if (pos_ff < count_ff &&
                         put_ff.base + put_ff.len == next_ff.base && sum_c <= LenMax) begin
               cmd_c.wr_en   = 1'b1;
               cmd_c.wr_addr = pos_ff[IdxBits-1:0];
               cmd_c.wr_data = '{len: sum_c[AddrBits-1:0], base: put_ff.base};
            end else if (count_ff >= cnt_type'(MaxSegments)) begin
               status_in = ST_FULL;
            end else begin
               idx_in   = count_ff;
               state_in = S_SHIFT_R;
            end
         end

         S_SHIFT_L: begin
            // entry k <- entry k+1 for k from idx up to count-2
            if (idx_ff + 1'b1 < count_ff && !rvld_ff) begin
               cmd_c.rd_en   = 1'b1;
               cmd_c.rd_addr = idx_ff[IdxBits-1:0] + 1'b1;
               rvld_in       = 1'b1;
            end else if (rvld_ff) begin
               cmd_c.wr_en   = 1'b1;
               cmd_c.wr_addr = idx_ff[IdxBits-1:0];
               cmd_c.wr_data = rd_data;
               idx_in        = idx_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_SHIFT_R: begin
            // entry k <- entry k-1 for k from count down to pos+1
            if (idx_ff > pos_ff && !rvld_ff) begin
               cmd_c.rd_en   = 1'b1;
               cmd_c.rd_addr = idx_ff[IdxBits-1:0] - 1'b1;
               rvld_in       = 1'b1;
            end else if (rvld_ff) begin
               cmd_c.wr_en   = 1'b1;
               cmd_c.wr_addr = idx_ff[IdxBits-1:0];
               cmd_c.wr_data = rd_data;
               idx_in        = idx_ff - 1'b1;
            end else begin
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            cmd_c.wr_en   = 1'b1;
            cmd_c.wr_addr = pos_ff[IdxBits-1:0];
            cmd_c.wr_data = put_ff;
            count_in      = count_ff + 1'b1;
            state_in      = S_DONE;
         end

         // hold the result until the output register is free
         S_DONE: if (out_ready) state_in = S_IDLE;

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rvld_ff  <= rvld_in;
      end
      idx_ff     <= idx_in;
      ridx_ff    <= ridx_in;
      found_ff   <= found_in;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
      prev_ff    <= prev_in;
      next_ff    <= next_in;
      pos_ff     <= pos_in;
      put_ff     <= put_in;
      is_free_ff <= is_free_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign cmd     = cmd_c;
   assign done    = (state_ff == S_DONE);
   assign status  = status_ff;
   assign granted = granted_ff;
   assign count   = count_ff;

endmodule
`default_nettype wire

[rtl/worst_fit_segment_allocator.sv]
`default_nettype none
// channel  direction  tdata (low bit up)
// req      in         action[1:0], request_length[17:2], free_base[33:18], pad to 40
// rsp      out        status[1:0], granted_base[17:2], free_count[22:18], pad to 24
// csr      in         total_size[15:0], written when csr_wr_en is high
//
// Init, the unused action and zero length need no table scan. An allocate
// scans every entry and moves the later entries down when the picked segment
// empties; a free scans up to the first entry above its base and moves entries
// on insert or merge. Reset empties the table; nothing is held until the first
// init. While a response waits on rsp_tready, one more request runs and holds
// its result until the output register frees; req_tready stays low meanwhile.
module worst_fit_segment_allocator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data
);
   import wfsa_pkg::*;

   addr_type    total_size_ff;
   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   mem_cmd_type cmd;
   seg_type     rd_data;
   logic        done;
   logic [1:0]  status;
   addr_type    granted;
   cnt_type     count;
   logic        start;
   logic        out_free;

   assign req_tready = !busy_ff;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   wfsa_seg_ram u_ram (.clock(clock), .cmd(cmd), .rd_data(rd_data));

   wfsa_seq u_seq (
      .clock(clock), .reset(reset), .start(start), .out_ready(out_free),
      .action(req_tdata[1:0]), .req_len(req_tdata[17:2]),
      .req_base(req_tdata[33:18]), .total_size(total_size_ff),
      .rd_data(rd_data), .cmd(cmd), .done(done), .status(status),
      .granted(granted), .count(count)
   );

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (start) busy_in = 1'b1;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done && out_free) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, count, granted, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         total_size_ff <= 16'hFFFF;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) total_size_ff <= csr_wr_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/wfsa_checker.sv]
`default_nettype none
module wfsa_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [23:0] rsp_tdata
);
   // hold response under stall
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped under stall");

   // one request at a time: busy right after acceptance
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // count never exceeds table depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:18] <= 5'd16)
      else $error("free count out of range");

   // granted base is zero unless status ok
   a_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[17:2] == 16'd0)
      else $error("granted base on failed request");
endmodule

bind worst_fit_segment_allocator wfsa_checker u_wfsa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
